FILE: design/rgbled_pkg.sv
package rgbled_pkg;

  localparam int unsigned ColorW = 24;
  localparam int unsigned TickW  = 12;
  localparam int unsigned GapW   = 10;
  localparam int unsigned LevelW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Position of the first (most significant) bit of a pixel on the line.
  localparam logic [4:0] BitPosFirst = 5'd23;

  // Register reset values.
  localparam logic [TickW-1:0]  BitPeriodRst  = 12'd200;
  localparam logic [TickW-1:0]  OneHighRst    = 12'd136;
  localparam logic [TickW-1:0]  ZeroHighRst   = 12'd40;
  localparam logic [GapW-1:0]   ResetGapRst   = 10'd80;
  localparam logic [LevelW-1:0] OnLevelRst    = 8'h0F;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_PERIOD = 3'd0,
    CFG_ONE_HIGH   = 3'd1,
    CFG_ZERO_HIGH  = 3'd2,
    CFG_RESET_GAP  = 3'd3,
    CFG_ON_LEVEL   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_TX    = 2'd1,
    MODE_POWER = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PWR_BLUE  = 2'd0,
    PWR_RED   = 2'd1,
    PWR_GREEN = 2'd2,
    PWR_NONE  = 2'd3
  } power_e;

endpackage

FILE: design/rgb_led_chain_status_encoder.sv
// Status encoder for a chain of addressable RGB LEDs on a one-wire line. Each input
// transaction is either a command (set receive, set transmit or set power, selected by
// tuser) that updates the per-pixel green-red-blue colours, or a tick that advances the
// line waveform by one tick. A real colour change, and reset itself, queue a frame,
// which the next tick with the line idle starts: a low reset gap of reset_gap_periods
// bit periods followed by PIXELS*24 data bits, most significant first, each high for
// one_high_ticks or zero_high_ticks. Every input transaction yields exactly one result
// transaction carrying the line level, the busy flag and, on tlast, the end of the
// frame. The block takes one transaction per clock cycle; its result appears in the next cycle
// in the single output register. While that result waits on m_axis_tready no new
// transaction is taken; the next one is taken in the same cycle as the waiting result
// leaves. Configuration writes are always taken and act from the next cycle on.
module rgb_led_chain_status_encoder #(
  parameter int unsigned PIXELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel [7:0], status [9:8], zero [15:10]
  input  logic [15:0]                         s_axis_tdata,
  // mode [1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // line_level [0], busy_res [1], zero [7:2]
  output logic [7:0]                          m_axis_tdata,
  // frame_done
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rgbled_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rgbled_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned PixW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [PixW-1:0] PixLast = PixW'(PIXELS - 1);

  // Configuration registers.
  logic [rgbled_pkg::TickW-1:0]  period_q, one_high_q, zero_high_q;
  logic [rgbled_pkg::GapW-1:0]   gap_len_q;
  logic [rgbled_pkg::LevelW-1:0] on_level_q;

  // Pixel colours and line state.
  logic [rgbled_pkg::ColorW-1:0] pixel_q [PIXELS];
  logic                          pending_q, pending_d;
  logic                          sending_q, sending_d;
  logic                          in_gap_q, in_gap_d;
  logic [rgbled_pkg::GapW-1:0]   gap_cnt_q, gap_cnt_d;
  logic [PixW-1:0]               pix_q, pix_d;
  logic [4:0]                    pos_q, pos_d;
  logic [rgbled_pkg::TickW-1:0]  tick_q, tick_d;

  // Output register.
  logic out_valid_q;
  logic level_q, level_d;
  logic busy_q, busy_d;
  logic done_q, done_d;

  logic                          accept;
  rgbled_pkg::mode_e             mode;
  logic [7:0]                    channel;
  logic [1:0]                    status;
  logic [PixW-1:0]               chan_sel;
  logic [rgbled_pkg::LevelW-1:0] comp_val;
  logic                          wr_en;
  logic [PixW-1:0]               wr_idx;
  logic [rgbled_pkg::ColorW-1:0] wr_color;
  logic [rgbled_pkg::ColorW-1:0] old_color;
  logic                          start;
  logic                          snd, gap;
  logic [PixW-1:0]               pix_cur;
  logic [4:0]                    pos_cur;
  logic [rgbled_pkg::TickW-1:0]  tick_cur;
  logic [rgbled_pkg::GapW-1:0]   gap_cnt_cur;
  logic [rgbled_pkg::ColorW-1:0] cur_color;
  logic                          data_bit;
  logic [rgbled_pkg::TickW-1:0]  high_ticks;
  logic [rgbled_pkg::TickW:0]    tick_next;
  logic [rgbled_pkg::GapW:0]     gap_next;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign mode    = rgbled_pkg::mode_e'(s_axis_tuser);
  assign channel = s_axis_tdata[7:0];
  assign status  = s_axis_tdata[9:8];

  assign chan_sel = ({1'b0, channel} >= 9'(PIXELS)) ? PixLast : channel[PixW-1:0];
  assign comp_val = (status != 2'd0) ? on_level_q : '0;

  // Colour write for command transactions; only a real change queues a frame.
  always_comb begin
    wr_idx   = chan_sel;
    wr_color = pixel_q[chan_sel];
    unique case (mode)
      rgbled_pkg::MODE_RX: begin
        wr_color = {pixel_q[chan_sel][23:8], comp_val};
      end
      rgbled_pkg::MODE_TX: begin
        wr_color = {comp_val, pixel_q[chan_sel][15:0]};
      end
      rgbled_pkg::MODE_POWER: begin
        wr_idx = '0;
        case (rgbled_pkg::power_e'(status))
          rgbled_pkg::PWR_BLUE:  wr_color = {16'd0, on_level_q};
          rgbled_pkg::PWR_RED:   wr_color = {8'd0, on_level_q, 8'd0};
          rgbled_pkg::PWR_GREEN: wr_color = {on_level_q, 16'd0};
          default:               wr_color = pixel_q[0];
        endcase
      end
      default: begin
        wr_color = pixel_q[chan_sel];
      end
    endcase
  end

  assign old_color = pixel_q[wr_idx];
  assign wr_en     = accept && (mode != rgbled_pkg::MODE_TICK) && (wr_color != old_color);

  // A tick with nothing on the line and a frame queued becomes the first gap tick.
  assign start       = (mode == rgbled_pkg::MODE_TICK) && !sending_q && pending_q;
  assign snd         = sending_q || start;
  assign gap         = start ? 1'b1 : in_gap_q;
  assign pix_cur     = start ? '0 : pix_q;
  assign pos_cur     = start ? rgbled_pkg::BitPosFirst : pos_q;
  assign tick_cur    = start ? '0 : tick_q;
  assign gap_cnt_cur = start ? '0 : gap_cnt_q;

  // Data bits are taken live, including a colour written by this very transaction.
  assign cur_color  = (wr_en && (wr_idx == pix_cur)) ? wr_color : pixel_q[pix_cur];
  assign data_bit   = cur_color[pos_cur];
  assign high_ticks = data_bit ? one_high_q : zero_high_q;
  assign tick_next  = {1'b0, tick_cur} + 13'd1;
  assign gap_next   = {1'b0, gap_cnt_cur} + 11'd1;

  always_comb begin
    pending_d = pending_q;
    sending_d = sending_q;
    in_gap_d  = in_gap_q;
    gap_cnt_d = gap_cnt_q;
    pix_d     = pix_q;
    pos_d     = pos_q;
    tick_d    = tick_q;
    level_d   = snd && !gap && (tick_cur < high_ticks);
    busy_d    = snd;
    done_d    = 1'b0;
    if (mode != rgbled_pkg::MODE_TICK) begin
      level_d = sending_q && !in_gap_q && (tick_q < high_ticks);
      busy_d  = sending_q;
      if (wr_en) begin
        pending_d = 1'b1;
      end
    end else if (snd) begin
      if (start) begin
        pending_d = 1'b0;
      end
      sending_d = 1'b1;
      in_gap_d  = gap;
      gap_cnt_d = gap_cnt_cur;
      pix_d     = pix_cur;
      pos_d     = pos_cur;
      tick_d    = tick_next[rgbled_pkg::TickW-1:0];
      // A period of zero ticks ends after one tick, as does a wrapped counter.
      if (tick_next >= {1'b0, period_q}) begin
        tick_d = '0;
        if (gap) begin
          gap_cnt_d = gap_next[rgbled_pkg::GapW-1:0];
          if (gap_next >= {1'b0, gap_len_q}) begin
            in_gap_d  = 1'b0;
            gap_cnt_d = '0;
            pix_d     = '0;
            pos_d     = rgbled_pkg::BitPosFirst;
          end
        end else if (pos_cur == 5'd0) begin
          pos_d = rgbled_pkg::BitPosFirst;
          if (pix_cur == PixLast) begin
            sending_d = 1'b0;
            pix_d     = '0;
            done_d    = 1'b1;
          end else begin
            pix_d = pix_cur + PixW'(1);
          end
        end else begin
          pos_d = pos_cur - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= rgbled_pkg::BitPeriodRst;
      one_high_q  <= rgbled_pkg::OneHighRst;
      zero_high_q <= rgbled_pkg::ZeroHighRst;
      gap_len_q   <= rgbled_pkg::ResetGapRst;
      on_level_q  <= rgbled_pkg::OnLevelRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rgbled_pkg::cfg_idx_e'(cfg_index_i))
        rgbled_pkg::CFG_BIT_PERIOD: period_q    <= cfg_data_i;
        rgbled_pkg::CFG_ONE_HIGH:   one_high_q  <= cfg_data_i;
        rgbled_pkg::CFG_ZERO_HIGH:  zero_high_q <= cfg_data_i;
        rgbled_pkg::CFG_RESET_GAP:  gap_len_q   <= cfg_data_i[rgbled_pkg::GapW-1:0];
        rgbled_pkg::CFG_ON_LEVEL:   on_level_q  <= cfg_data_i[rgbled_pkg::LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIXELS; i++) begin
        pixel_q[i] <= '0;
      end
    end else if (wr_en) begin
      pixel_q[wr_idx] <= wr_color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b1;
      sending_q <= 1'b0;
      in_gap_q  <= 1'b0;
      gap_cnt_q <= '0;
      pix_q     <= '0;
      pos_q     <= rgbled_pkg::BitPosFirst;
      tick_q    <= '0;
    end else if (accept) begin
      pending_q <= pending_d;
      sending_q <= sending_d;
      in_gap_q  <= in_gap_d;
      gap_cnt_q <= gap_cnt_d;
      pix_q     <= pix_d;
      pos_q     <= pos_d;
      tick_q    <= tick_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q <= level_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, busy_q, level_q};
  assign m_axis_tlast  = done_q;

  // The gap only exists inside a frame.
  a_gap_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_gap_q |-> sending_q)
    else $error("gap flag set outside a frame");

  // Between frames the bit counters sit at the start of pixel 0.
  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (pix_q == '0) && (pos_q == rgbled_pkg::BitPosFirst) && (tick_q == '0)
                   && (gap_cnt_q == '0))
    else $error("bit counters not cleared between frames");

  // The bit position never leaves the 24 bits of a pixel.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= rgbled_pkg::BitPosFirst)
    else $error("bit position out of range");

  // The transaction that ends a frame was sent while busy, and leaves the line idle.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> busy_q && !sending_q)
    else $error("frame end reported outside a frame");

  // A frame can only start from a queued one.
  a_start_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !sending_q && sending_d) |-> pending_q)
    else $error("frame started without a queued frame");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned PIXELS     = 8;
  localparam int unsigned FrameBits  = PIXELS * 24;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } line_res_t;

  typedef struct packed {
    rgbled_pkg::mode_e mode;
    logic [7:0]        chan;
    logic [1:0]        status;
    logic              typed;
    line_res_t         res;
  } stim_row_t;

  localparam line_res_t Quiet = '{level: 1'b0, busy: 1'b0, done: 1'b0};
  localparam line_res_t InGap = '{level: 1'b0, busy: 1'b1, done: 1'b0};
  localparam int DirN = 18;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [rgbled_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [rgbled_pkg::CfgDataW-1:0] cfg_data_i = '0;

  rgb_led_chain_status_encoder #(
    .PIXELS(PIXELS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the encoder: registers, pixel store and line sequencer.
  logic [rgbled_pkg::TickW-1:0]  period_r = rgbled_pkg::BitPeriodRst;
  logic [rgbled_pkg::TickW-1:0]  one_high_r = rgbled_pkg::OneHighRst;
  logic [rgbled_pkg::TickW-1:0]  zero_high_r = rgbled_pkg::ZeroHighRst;
  logic [rgbled_pkg::GapW-1:0]   gap_len_r = rgbled_pkg::ResetGapRst;
  logic [rgbled_pkg::LevelW-1:0] on_level_r = rgbled_pkg::OnLevelRst;
  logic [23:0]       shadow_pixels [PIXELS];
  bit                frame_queued = 1'b1;
  bit                line_busy = 1'b0;
  bit                line_in_gap = 1'b0;
  logic [10:0]       bit_pos = '0;
  logic [11:0]       tick_pos = '0;

  line_res_t   expected_line_q [$];
  stim_row_t   dir_rows [DirN];
  int unsigned err_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned settings_done = 1;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle_pct = 31;
  int unsigned sink_idle_pct = 56;
  logic        hold_req = 1'b0;
  logic        hold_active = 1'b0;
  int unsigned hold_cycles = 0;

  function automatic logic data_line_level();
    int unsigned pix;
    int unsigned pos;
    logic        bit_val;
    logic [11:0] high;
    if (!line_busy || line_in_gap) begin
      return 1'b0;
    end
    pix = bit_pos / 24;
    pos = 23 - (bit_pos % 24);
    bit_val = (pix < PIXELS) ? shadow_pixels[pix][pos] : 1'b0;
    high = bit_val ? one_high_r : zero_high_r;
    return (tick_pos < high);
  endfunction

  task automatic paint_pixel(input int unsigned idx, input logic [23:0] colour);
    if (shadow_pixels[idx] != colour) begin
      shadow_pixels[idx] = colour;
      frame_queued = 1'b1;
    end
  endtask

  task automatic predict_line(input rgbled_pkg::mode_e mode, input logic [7:0] chan,
                              input logic [1:0] status, output line_res_t res);
    int unsigned idx;
    logic [7:0]  comp;
    idx = (chan >= PIXELS) ? PIXELS - 1 : chan;
    comp = (status != 2'd0) ? on_level_r : 8'h00;
    res.done = 1'b0;
    case (mode)
      rgbled_pkg::MODE_RX: begin
        paint_pixel(idx, {shadow_pixels[idx][23:8], comp});
      end
      rgbled_pkg::MODE_TX: begin
        paint_pixel(idx, {comp, shadow_pixels[idx][15:0]});
      end
      rgbled_pkg::MODE_POWER: begin
        case (rgbled_pkg::power_e'(status))
          rgbled_pkg::PWR_BLUE:  paint_pixel(0, {16'h0000, on_level_r});
          rgbled_pkg::PWR_RED:   paint_pixel(0, {8'h00, on_level_r, 8'h00});
          rgbled_pkg::PWR_GREEN: paint_pixel(0, {on_level_r, 16'h0000});
          default: ;
        endcase
      end
      default: begin
        if (!line_busy && frame_queued) begin
          frame_queued = 1'b0;
          line_busy = 1'b1;
          line_in_gap = 1'b1;
          bit_pos = '0;
          tick_pos = '0;
        end
        res.level = data_line_level();
        res.busy = line_busy;
        if (line_busy) begin
          tick_pos = tick_pos + 12'd1;
          // A zero period behaves as one tick, a zero gap as one period.
          if (tick_pos >= period_r || tick_pos == 12'd0) begin
            tick_pos = '0;
            bit_pos = bit_pos + 11'd1;
            if (line_in_gap) begin
              if (bit_pos >= gap_len_r || bit_pos == 11'd0) begin
                line_in_gap = 1'b0;
                bit_pos = '0;
              end
            end else if (bit_pos >= FrameBits || bit_pos == 11'd0) begin
              line_busy = 1'b0;
              bit_pos = '0;
              res.done = 1'b1;
            end
          end
        end
        return;
      end
    endcase
    // Commands leave the line alone but report it with the colours already updated.
    res.level = data_line_level();
    res.busy = line_busy;
  endtask

  task automatic log_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic send_item(input rgbled_pkg::mode_e mode, input logic [7:0] chan,
                           input logic [1:0] status, input logic typed,
                           input line_res_t typed_res);
    line_res_t res;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b000000, status, chan};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    predict_line(mode, chan, status, res);
    expected_line_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic write_reg(input rgbled_pkg::cfg_idx_e idx,
                           input logic [rgbled_pkg::CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      rgbled_pkg::CFG_BIT_PERIOD: period_r = value;
      rgbled_pkg::CFG_ONE_HIGH:   one_high_r = value;
      rgbled_pkg::CFG_ZERO_HIGH:  zero_high_r = value;
      rgbled_pkg::CFG_RESET_GAP:  gap_len_r = value[rgbled_pkg::GapW-1:0];
      rgbled_pkg::CFG_ON_LEVEL:   on_level_r = value[rgbled_pkg::LevelW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [11:0] period, input logic [11:0] one_high,
                               input logic [11:0] zero_high, input logic [9:0] gap_len,
                               input logic [7:0] level);
    write_reg(rgbled_pkg::CFG_BIT_PERIOD, period);
    write_reg(rgbled_pkg::CFG_ONE_HIGH, one_high);
    write_reg(rgbled_pkg::CFG_ZERO_HIGH, zero_high);
    write_reg(rgbled_pkg::CFG_RESET_GAP, {2'b00, gap_len});
    write_reg(rgbled_pkg::CFG_ON_LEVEL, {4'h0, level});
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  task automatic wait_drained();
    while (expected_line_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly ticks so that frames run to their end; commands hit the real pixels
  // most of the time and the clamped range now and then.
  task automatic run_random(input int unsigned count, input int unsigned tick_pct,
                            input bit with_hold);
    rgbled_pkg::mode_e mode;
    logic [7:0]        chan;
    logic [1:0]        status;
    for (int unsigned i = 0; i < count; i++) begin
      chan = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, PIXELS - 1));
      status = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < tick_pct) begin
        mode = rgbled_pkg::MODE_TICK;
      end else begin
        mode = rgbled_pkg::mode_e'($urandom_range(0, 2));
      end
      send_item(mode, chan, status, 1'b0, Quiet);
      if (with_hold && i == 40) begin
        hold_req <= 1'b1;
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Long receiver stall, timed here so the sender keeps offering meanwhile.
  always @(posedge clk_i) begin
    if (hold_active) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HoldLen - 1) begin
        hold_active <= 1'b0;
      end
    end else if (hold_req && hold_cycles == 0) begin
      hold_active <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    line_res_t got;
    line_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{level: m_axis_tdata[0], busy: m_axis_tdata[1], done: m_axis_tlast};
      results_seen++;
      if (expected_line_q.size() == 0) begin
        log_mismatch($sformatf("result level=%b busy=%b done=%b with nothing expected",
                               got.level, got.busy, got.done));
      end else begin
        want = expected_line_q.pop_front();
        if (got !== want) begin
          log_mismatch($sformatf("result %0d: level %b/%b busy %b/%b done %b/%b (got/exp)",
                                 results_seen, got.level, want.level, got.busy, want.busy,
                                 got.done, want.done));
        end
        if (got.done === 1'b1) begin
          frames_seen++;
        end
      end
    end
    m_axis_tready <= hold_active ? 1'b0 : ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("rgb_led_chain_status_encoder regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < PIXELS; i++) begin
      shadow_pixels[i] = '0;
    end
    // Default timing after reset: the first frame sits in its long gap throughout.
    dir_rows = '{
      '{rgbled_pkg::MODE_RX,    8'd0,   2'd0,                  1'b1, Quiet},
      '{rgbled_pkg::MODE_TX,    8'd255, 2'd3,                  1'b1, Quiet},
      '{rgbled_pkg::MODE_POWER, 8'd0,   rgbled_pkg::PWR_NONE,  1'b1, Quiet},
      '{rgbled_pkg::MODE_RX,    8'd8,   2'd1,                  1'b1, Quiet},
      '{rgbled_pkg::MODE_TICK,  8'd0,   2'd0,                  1'b1, InGap},
      '{rgbled_pkg::MODE_TICK,  8'd255, 2'd3,                  1'b1, InGap},
      '{rgbled_pkg::MODE_POWER, 8'd0,   rgbled_pkg::PWR_BLUE,  1'b1, InGap},
      '{rgbled_pkg::MODE_POWER, 8'd17,  rgbled_pkg::PWR_RED,   1'b1, InGap},
      '{rgbled_pkg::MODE_POWER, 8'd255, rgbled_pkg::PWR_GREEN, 1'b1, InGap},
      '{rgbled_pkg::MODE_POWER, 8'd0,   rgbled_pkg::PWR_GREEN, 1'b1, InGap},
      '{rgbled_pkg::MODE_TX,    8'd0,   2'd1,                  1'b1, InGap},
      '{rgbled_pkg::MODE_RX,    8'd0,   2'd2,                  1'b1, InGap},
      '{rgbled_pkg::MODE_TX,    8'd7,   2'd0,                  1'b1, InGap},
      '{rgbled_pkg::MODE_RX,    8'd3,   2'd1,                  1'b0, Quiet},
      '{rgbled_pkg::MODE_RX,    8'd3,   2'd3,                  1'b0, Quiet},
      '{rgbled_pkg::MODE_TX,    8'd200, 2'd2,                  1'b0, Quiet},
      '{rgbled_pkg::MODE_TICK,  8'd128, 2'd1,                  1'b0, Quiet},
      '{rgbled_pkg::MODE_RX,    8'd6,   2'd0,                  1'b0, Quiet}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirN; i++) begin
      send_item(dir_rows[i].mode, dir_rows[i].chan, dir_rows[i].status,
                dir_rows[i].typed, dir_rows[i].res);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    apply_setting(12'd3, 12'd2, 12'd1, 10'd2, 8'hA5);
    run_random(150, 85, 1'b0);
    wait_drained();

    // Zero period and zero gap, with a one bit high for the whole period.
    apply_setting(12'd0, 12'd4095, 12'd0, 10'd0, 8'hFF);
    run_random(300, 90, 1'b0);
    wait_drained();

    src_idle_pct = 56;
    sink_idle_pct = 31;
    apply_setting(12'd4095, 12'd4095, 12'd2048, 10'd1023, 8'h00);
    run_random(100, 70, 1'b0);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    apply_setting(12'd1, 12'd1, 12'd0, 10'd1, 8'h3C);
    run_random(250, 90, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (expected_line_q.size() != 0) begin
      log_mismatch($sformatf("%0d expected results never arrived", expected_line_q.size()));
    end
    $display("Sent %0d command and tick transactions under %0d timing settings.",
             items_sent, settings_done);
    $display("Checked %0d results, %0d completed frames seen, %0d mismatches.",
             results_seen, frames_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("rgb_led_chain_status_encoder regression: pass");
    end else begin
      $display("rgb_led_chain_status_encoder regression: fail");
    end
    $finish;
  end

endmodule
